[design/bpvc_pkg.sv]
package bpvc_pkg;

  // table depth must be a power of two: start index and probe wrap are masks
  localparam int CACHE_DEPTH = 4096;
  localparam int PROBE_LIMIT = 32;

  localparam int IDX_W   = $clog2(CACHE_DEPTH);
  localparam int PROBE_W = $clog2(PROBE_LIMIT + 1);
  localparam int KEY_W   = 64;
  localparam int SLOT_W  = 8;
  localparam int GEN_W   = 32;
  localparam int CNT_W   = 32;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

[design/bpvc_table.sv]
module bpvc_table (
  input  logic              clk,
  input  bpvc_pkg::tbl_rd_t rd,
  output bpvc_pkg::entry_t  rd_data,
  input  bpvc_pkg::tbl_wr_t wr
);

  bpvc_pkg::entry_t mem [bpvc_pkg::CACHE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[design/bounded_probe_view_cache_unit.sv]
// an item is taken in ST_IDLE with the first table read, probed in ST_PROBE, sent from ST_DONE
// no new item is taken until ST_DONE has registered the last result; one table read a cycle
// zero key, unused op code and clear skip ST_PROBE and go from ST_IDLE straight to ST_DONE
// clear and reset run a sweep over all CACHE_DEPTH table entries, s_axis_tready low
// reset is synchronous: zeroes counter, drops output valid, starts the sweep
module bounded_probe_view_cache_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key[63:0], slot_in[71:64], generation_in[103:72]
  input  logic [103:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // hit[0], slot_out[8:1], generation_out[40:9], replaced[41], replacements[73:42], zero pad
  output logic [79:0] m_axis_tdata
);

  localparam int IDX_W   = bpvc_pkg::IDX_W;
  localparam int PROBE_W = bpvc_pkg::PROBE_W;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_PROBE, ST_DONE} state_t;

  state_t state;

  logic [bpvc_pkg::OP_W-1:0]   op_r;
  logic [bpvc_pkg::KEY_W-1:0]  key_r;
  logic [bpvc_pkg::SLOT_W-1:0] slot_r;
  logic [bpvc_pkg::GEN_W-1:0]  gen_r;
  logic [IDX_W-1:0]            start_r;
  logic [IDX_W-1:0]            probe_addr;
  logic [PROBE_W-1:0]          probe;
  logic [IDX_W-1:0]            clr_addr;
  logic                        clear_pend;
  logic [bpvc_pkg::CNT_W-1:0]  repl_cnt;

  logic                        res_hit;
  logic [bpvc_pkg::SLOT_W-1:0] res_slot;
  logic [bpvc_pkg::GEN_W-1:0]  res_gen;
  logic                        res_replaced;
  logic [bpvc_pkg::CNT_W-1:0]  res_repl;

  bpvc_pkg::tbl_rd_t rd;
  bpvc_pkg::tbl_wr_t wr;
  bpvc_pkg::entry_t  cur;

  logic [bpvc_pkg::OP_W-1:0]  in_op;
  logic [bpvc_pkg::KEY_W-1:0] in_key;
  logic [IDX_W-1:0]           in_start;
  logic                       accept;
  logic                       is_match;
  logic                       is_empty;
  logic                       is_last;
  logic                       out_free;

  function automatic logic [IDX_W-1:0] start_of(input logic [bpvc_pkg::KEY_W-1:0] k);
    logic [bpvc_pkg::KEY_W-1:0] h;
    h = (k >> 4) ^ (k >> 13);
    return h[IDX_W-1:0];
  endfunction

  bpvc_table u_table (
    .clk     (clk),
    .rd      (rd),
    .rd_data (cur),
    .wr      (wr)
  );

  assign in_op    = s_axis_tuser;
  assign in_key   = s_axis_tdata[63:0];
  assign in_start = start_of(in_key);

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign is_match = (cur.key == key_r);
  assign is_empty = (cur.key == '0);
  assign is_last  = (probe == PROBE_W'(bpvc_pkg::PROBE_LIMIT - 1));

  always_comb begin
    rd      = '0;
    wr      = '0;
    wr.data = '{key: key_r, slot: slot_r, gen: gen_r};
    case (state)
      ST_IDLE: begin
        rd.en   = accept;
        rd.addr = in_start;
      end
      ST_PROBE: begin
        // fetch the next entry speculatively while the current one is checked
        rd.en   = 1'b1;
        rd.addr = probe_addr + IDX_W'(1);
        if (op_r == bpvc_pkg::OP_INSERT) begin
          if (is_match || is_empty) begin
            wr.en   = 1'b1;
            wr.addr = probe_addr;
          end else if (is_last) begin
            wr.en   = 1'b1;
            wr.addr = start_r;
          end
        end
      end
      ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_addr;
        wr.data = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      clear_pend    <= 1'b0;
      repl_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !(state == ST_DONE && out_free)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(bpvc_pkg::CACHE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r         <= in_op;
            key_r        <= in_key;
            slot_r       <= s_axis_tdata[71:64];
            gen_r        <= s_axis_tdata[103:72];
            start_r      <= in_start;
            probe_addr   <= in_start;
            probe        <= '0;
            res_hit      <= 1'b0;
            res_slot     <= '0;
            res_gen      <= '0;
            res_replaced <= 1'b0;
            res_repl     <= (in_op == bpvc_pkg::OP_CLEAR) ? '0 : repl_cnt;
            if ((in_op == bpvc_pkg::OP_LOOKUP || in_op == bpvc_pkg::OP_INSERT)
                && in_key != '0) begin
              state <= ST_PROBE;
            end else if (in_op == bpvc_pkg::OP_CLEAR) begin
              repl_cnt   <= '0;
              clear_pend <= 1'b1;
              state      <= ST_DONE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_PROBE: begin
          if (op_r == bpvc_pkg::OP_LOOKUP) begin
            if (is_match) begin
              res_hit  <= 1'b1;
              res_slot <= cur.slot;
              res_gen  <= cur.gen;
              state    <= ST_DONE;
            end else if (is_empty || is_last) begin
              state <= ST_DONE;
            end else begin
              probe      <= probe + PROBE_W'(1);
              probe_addr <= probe_addr + IDX_W'(1);
            end
          end else begin
            if (is_match || is_empty) begin
              state <= ST_DONE;
            end else if (is_last) begin
              // no room in the probe window: start entry was overwritten
              repl_cnt     <= repl_cnt + bpvc_pkg::CNT_W'(1);
              res_repl     <= repl_cnt + bpvc_pkg::CNT_W'(1);
              res_replaced <= 1'b1;
              state        <= ST_DONE;
            end else begin
              probe      <= probe + PROBE_W'(1);
              probe_addr <= probe_addr + IDX_W'(1);
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'b0, res_repl, res_replaced, res_gen, res_slot, res_hit};
            clear_pend    <= 1'b0;
            clr_addr      <= '0;
            state         <= clear_pend ? ST_CLEAR : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_hit_not_replaced: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[41]))
    else $error("result reports both hit and replaced");

  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (repl_cnt != $past(repl_cnt)) |->
      (repl_cnt == $past(repl_cnt) + bpvc_pkg::CNT_W'(1) || repl_cnt == '0))
    else $error("replacement counter moved by other than one step or clear");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (probe < PROBE_W'(bpvc_pkg::PROBE_LIMIT)))
    else $error("probe count ran past the probe limit");

  a_write_on_insert: assert property (@(posedge clk) disable iff (rst)
    (wr.en && state == ST_PROBE) |-> (op_r == bpvc_pkg::OP_INSERT && key_r != '0))
    else $error("table written outside an insert");

endmodule
